### hw/rtl/yv12_to_yuy2_chroma_upsampler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chroma upsampler
// Clocked on clk_i; the plain form is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef YV12_TO_YUY2_CHROMA_UPSAMPLER_ASSERT_SVH
`define YV12_TO_YUY2_CHROMA_UPSAMPLER_ASSERT_SVH

// property checked outside reset
`define UPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked at every edge, reset included
`define UPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/yv2yuy_pkg.sv
// ----------------------------------------------------------------------------
// yv2yuy_pkg
// Shared types, register indexes, mode codes and weight tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package yv2yuy_pkg;

  localparam logic [11:0] MAX_PAIRS = 12'd2048;
  localparam logic [12:0] MAX_ROWS  = 13'd4096;

  localparam logic [1:0] CFG_MODE       = 2'd0;
  localparam logic [1:0] CFG_LINE_PAIRS = 2'd1;
  localparam logic [1:0] CFG_FRAME_ROWS = 2'd2;

  localparam logic [2:0] MODE_FRAME1       = 3'd0;
  localparam logic [2:0] MODE_FRAME2       = 3'd1;
  localparam logic [2:0] MODE_FRAME3       = 3'd2;
  localparam logic [2:0] MODE_FRAME_TOP    = 3'd3;
  localparam logic [2:0] MODE_FRAME_BOTTOM = 3'd4;
  localparam logic [2:0] MODE_FIELD1       = 3'd5;
  localparam logic [2:0] MODE_FIELD2       = 3'd6;
  localparam logic [2:0] MODE_FIELD3       = 3'd7;

  localparam logic [11:0] RST_LINE_PAIRS = 12'd360;
  localparam logic [12:0] RST_FRAME_ROWS = 13'd480;

  typedef struct packed {
    logic [2:0]  mode;
    logic [11:0] line_pairs;
    logic [12:0] frame_rows;
  } cfg_t;

  typedef struct packed {
    logic [3:0] weight;
    logic       boundary;
    logic       row_end;
  } pos_t;

  // upper-sample weight of a frame mode, for odd or even interior rows
  function automatic logic [3:0] frame_weight(input logic [2:0] fmode, input logic odd);
    logic [3:0] w;
    case (fmode)
      MODE_FRAME1:       w = odd ? 4'd6 : 4'd2;
      MODE_FRAME2:       w = odd ? 4'd4 : 4'd0;
      MODE_FRAME3:       w = odd ? 4'd8 : 4'd4;
      MODE_FRAME_TOP:    w = odd ? 4'd5 : 4'd1;
      MODE_FRAME_BOTTOM: w = odd ? 4'd7 : 4'd3;
      default:           w = odd ? 4'd6 : 4'd2;
    endcase
    return w;
  endfunction

  // frame mode that a field mode applies to its top or bottom pass
  function automatic logic [2:0] pass_mode(input logic [2:0] mode, input logic bottom);
    logic [2:0] m;
    case (mode)
      MODE_FIELD1: m = bottom ? MODE_FRAME_BOTTOM : MODE_FRAME_TOP;
      MODE_FIELD2: m = bottom ? MODE_FRAME1 : MODE_FRAME2;
      MODE_FIELD3: m = bottom ? MODE_FRAME3 : MODE_FRAME1;
      default:     m = mode;
    endcase
    return m;
  endfunction

endpackage

### hw/rtl/yv12_to_yuy2_chroma_upsampler.sv
// ----------------------------------------------------------------------------
// yv12_to_yuy2_chroma_upsampler
// 4:2:0 to 4:2:2 chroma upsampler producing packed Y0,U,Y1,V pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one pixel pair per transfer
//   in raster order of output rows: two luma bytes and the U/V samples of the
//   chroma rows above and below. Output channel (out_valid_o/out_ready_i)
//   carries the packed pair and row_end_o on the last pair of each row.
//   Configuration (mode, line_pairs, frame_rows) is written through cfg_we_i,
//   cfg_index_i and cfg_data_i while no transfer is in flight.
//   Output valid rises in the cycle after an input transfer. Throughput is
//   one pair per cycle while the receiver keeps out_ready_i high; the U and V
//   lanes blend in parallel and the merge register is the only data-path register.
//   Reset clears the counters, drops the output valid and loads the default
//   configuration (frame1, 360 pairs, 480 rows).
//   When the receiver stalls, the output register holds its pair and
//   in_ready_o drops; a new input transfer is taken in the same cycle the
//   held pair is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "yv12_to_yuy2_chroma_upsampler_assert.svh"

module yv12_to_yuy2_chroma_upsampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  luma_first_i,
  input  logic [7:0]  luma_second_i,
  input  logic [7:0]  cb_upper_i,
  input  logic [7:0]  cb_lower_i,
  input  logic [7:0]  cr_upper_i,
  input  logic [7:0]  cr_lower_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_y0_o,
  output logic [7:0]  out_u_o,
  output logic [7:0]  out_y1_o,
  output logic [7:0]  out_v_o,
  output logic        row_end_o
);
  import yv2yuy_pkg::*;

  cfg_t       cfg_q, cfg_d;
  pos_t       pos;
  logic       accept;
  logic [7:0] lane_u, lane_v;

  logic       valid_q, valid_d;
  logic [7:0] y0_q, y1_q, u_q, v_q;
  logic       end_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODE:       cfg_d.mode       = cfg_data_i[2:0];
        CFG_LINE_PAIRS: cfg_d.line_pairs = cfg_data_i[11:0];
        CFG_FRAME_ROWS: cfg_d.frame_rows = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= MODE_FRAME1;
      cfg_q.line_pairs <= RST_LINE_PAIRS;
      cfg_q.frame_rows <= RST_FRAME_ROWS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  yv2yuy_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .advance_i (accept),
    .pos_o     (pos)
  );

  yv2yuy_lane u_lane_u (
    .weight_i   (pos.weight),
    .boundary_i (pos.boundary),
    .upper_i    (cb_upper_i),
    .lower_i    (cb_lower_i),
    .blend_o    (lane_u)
  );

  yv2yuy_lane u_lane_v (
    .weight_i   (pos.weight),
    .boundary_i (pos.boundary),
    .upper_i    (cr_upper_i),
    .lower_i    (cr_lower_i),
    .blend_o    (lane_v)
  );

  // merge lanes and luma into the output register
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      y0_q  <= luma_first_i;
      y1_q  <= luma_second_i;
      u_q   <= lane_u;
      v_q   <= lane_v;
      end_q <= pos.row_end;
    end
  end

  assign out_valid_o = valid_q;
  assign out_y0_o    = y0_q;
  assign out_u_o     = u_q;
  assign out_y1_o    = y1_q;
  assign out_v_o     = v_q;
  assign row_end_o   = end_q;

  `UPS_ASSERT(a_accept_to_valid, accept |=> out_valid_o, "accepted pair not presented")
  `UPS_ASSERT(a_stall_blocks_input, (out_valid_o && !out_ready_i) |-> !in_ready_o,
    "input taken while output stalled")
  `UPS_ASSERT(a_boundary_copy, (accept && pos.boundary) |=> (out_u_o == $past(cb_upper_i)),
    "boundary row U not copied from upper sample")
  `UPS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

### hw/rtl/yv2yuy_lane.sv
// ----------------------------------------------------------------------------
// yv2yuy_lane
// One chroma lane: weighted blend of upper and lower samples, or a copy of
// the upper sample on boundary rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yv2yuy_lane (
  input  logic [3:0] weight_i,
  input  logic       boundary_i,
  input  logic [7:0] upper_i,
  input  logic [7:0] lower_i,
  output logic [7:0] blend_o
);
  import yv2yuy_pkg::*;

  logic [3:0]  inv_weight;
  logic [11:0] sum;

  always_comb begin
    inv_weight = 4'd8 - weight_i;
    sum = 12'(weight_i) * 12'(upper_i) + 12'(inv_weight) * 12'(lower_i) + 12'd4;
    blend_o = boundary_i ? upper_i : sum[10:3];
  end

endmodule

### hw/rtl/yv2yuy_ctrl.sv
// ----------------------------------------------------------------------------
// yv2yuy_ctrl
// Column and row counters; derives pass geometry, boundary flag, blend
// weight and end of row for the current pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yv2yuy_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  yv2yuy_pkg::cfg_t  cfg_i,
  input  logic              advance_i,
  output yv2yuy_pkg::pos_t  pos_o
);
  import yv2yuy_pkg::*;

  logic [10:0] col_q, col_d;
  logic [11:0] row_q, row_d;

  logic        field;
  logic [11:0] last_col;
  logic [12:0] rows;
  logic [12:0] pass_rows;
  logic [12:0] total_rows;
  logic [11:0] idx;
  logic        row_wrap;

  always_comb begin
    field = cfg_i.mode inside {[MODE_FIELD1:MODE_FIELD3]};

    if (cfg_i.line_pairs == 12'd0) begin
      last_col = 12'd0;
    end else if (cfg_i.line_pairs > MAX_PAIRS) begin
      last_col = MAX_PAIRS - 12'd1;
    end else begin
      last_col = cfg_i.line_pairs - 12'd1;
    end

    rows = (cfg_i.frame_rows > MAX_ROWS) ? MAX_ROWS : cfg_i.frame_rows;
    if (field) begin
      pass_rows = {1'b0, rows[12:2], 1'b0};
    end else begin
      pass_rows = {rows[12:1], 1'b0};
    end
    if (pass_rows < 13'd2) begin
      pass_rows = 13'd2;
    end
    total_rows = field ? {pass_rows[11:0], 1'b0} : pass_rows;

    idx = field ? {1'b0, row_q[11:1]} : row_q;

    pos_o.boundary = (idx == 12'd0) || ({1'b0, idx} >= pass_rows - 13'd1);
    pos_o.weight   = frame_weight(pass_mode(cfg_i.mode, row_q[0]), idx[0]);
    pos_o.row_end  = {1'b0, col_q} >= last_col;
    row_wrap       = {1'b0, row_q} >= total_rows - 13'd1;

    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (pos_o.row_end) begin
        col_d = 11'd0;
        row_d = row_wrap ? 12'd0 : row_q + 12'd1;
      end else begin
        col_d = col_q + 11'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= 11'd0;
      row_q <= 12'd0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

### tb/sv/chroma_pair_checker.sv
// ----------------------------------------------------------------------------
// chroma_pair_checker
// Watches the configuration port and both pixel channels of the chroma
// upsampler, predicts each packed Y0,U,Y1,V pair from the accepted input
// pair and its own copy of mode, row size, frame height and counters, and
// compares every output transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chroma_pair_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  luma_first_i,
  input  logic [7:0]  luma_second_i,
  input  logic [7:0]  cb_upper_i,
  input  logic [7:0]  cb_lower_i,
  input  logic [7:0]  cr_upper_i,
  input  logic [7:0]  cr_lower_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_y0_i,
  input  logic [7:0]  out_u_i,
  input  logic [7:0]  out_y1_i,
  input  logic [7:0]  out_v_i,
  input  logic        row_end_i,
  output int          mismatches_o,
  output int          outstanding_o
);
  import yv2yuy_pkg::*;

  localparam int PAIR_LIMIT = 2048;
  localparam int ROW_LIMIT  = 4096;
  localparam int PRINT_CAP  = 40;

  typedef struct packed {
    logic [7:0] y0;
    logic [7:0] u;
    logic [7:0] y1;
    logic [7:0] v;
    logic       row_end;
  } yuy2_pair_t;

  yuy2_pair_t expected_pairs[$];
  logic [2:0] cur_mode;
  int         cur_pairs;
  int         cur_rows;
  int         col_pos;
  int         row_pos;
  int         n_mismatch;
  int         n_waiting;

  assign mismatches_o  = n_mismatch;
  assign outstanding_o = n_waiting;

  function automatic int upper_weight(input logic [2:0] fmode, input logic odd_row);
    int w;
    case (fmode)
      MODE_FRAME1:       w = odd_row ? 6 : 2;
      MODE_FRAME2:       w = odd_row ? 4 : 0;
      MODE_FRAME3:       w = odd_row ? 8 : 4;
      MODE_FRAME_TOP:    w = odd_row ? 5 : 1;
      default:           w = odd_row ? 7 : 3;
    endcase
    return w;
  endfunction

  function automatic logic [2:0] field_frame_mode(input logic [2:0] fld, input logic bottom);
    logic [2:0] m;
    case (fld)
      MODE_FIELD1: m = bottom ? MODE_FRAME_BOTTOM : MODE_FRAME_TOP;
      MODE_FIELD2: m = bottom ? MODE_FRAME1 : MODE_FRAME2;
      default:     m = bottom ? MODE_FRAME3 : MODE_FRAME1;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] mix(input int w, input logic [7:0] up, input logic [7:0] lo);
    int acc;
    acc = (w * up + (8 - w) * lo + 4) >> 3;
    return acc[7:0];
  endfunction

  function automatic yuy2_pair_t upsample_pair(input logic [7:0] y0, input logic [7:0] y1,
                                               input logic [7:0] cbu, input logic [7:0] cbl,
                                               input logic [7:0] cru, input logic [7:0] crl);
    int         pairs;
    int         rows;
    int         pass_rows;
    int         total_rows;
    int         idx;
    int         w;
    logic [2:0] fmode;
    yuy2_pair_t r;
    pairs = cur_pairs;
    rows  = cur_rows;
    if (pairs == 0) pairs = 1;
    if (pairs > PAIR_LIMIT) pairs = PAIR_LIMIT;
    if (rows > ROW_LIMIT) rows = ROW_LIMIT;
    if (cur_mode >= MODE_FIELD1) begin
      pass_rows  = (rows >> 1) & ~1;
      if (pass_rows < 2) pass_rows = 2;
      total_rows = pass_rows * 2;
      idx        = row_pos >> 1;
      fmode      = field_frame_mode(cur_mode, row_pos[0]);
    end else begin
      pass_rows  = rows & ~1;
      if (pass_rows < 2) pass_rows = 2;
      total_rows = pass_rows;
      idx        = row_pos;
      fmode      = cur_mode;
    end
    r.y0 = y0;
    r.y1 = y1;
    if (idx == 0 || idx >= pass_rows - 1) begin
      r.u = cbu;
      r.v = cru;
    end else begin
      w   = upper_weight(fmode, idx[0]);
      r.u = mix(w, cbu, cbl);
      r.v = mix(w, cru, crl);
    end
    r.row_end = (col_pos >= pairs - 1);
    if (r.row_end) begin
      col_pos = 0;
      row_pos = (row_pos >= total_rows - 1) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (n_mismatch < PRINT_CAP) begin
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    n_mismatch++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    yuy2_pair_t want;
    if (!rst_ni) begin
      expected_pairs.delete();
      cur_mode   = MODE_FRAME1;
      cur_pairs  = RST_LINE_PAIRS;
      cur_rows   = RST_FRAME_ROWS;
      col_pos    = 0;
      row_pos    = 0;
      n_waiting  = 0;
      n_mismatch = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_pairs.size() == 0) begin
          report_mismatch("transfer with nothing expected, y0", out_y0_i, -1);
        end else begin
          want = expected_pairs.pop_front();
          if (out_y0_i !== want.y0) report_mismatch("out_y0", out_y0_i, want.y0);
          if (out_u_i !== want.u) report_mismatch("out_u", out_u_i, want.u);
          if (out_y1_i !== want.y1) report_mismatch("out_y1", out_y1_i, want.y1);
          if (out_v_i !== want.v) report_mismatch("out_v", out_v_i, want.v);
          if (row_end_i !== want.row_end) report_mismatch("row_end", row_end_i, want.row_end);
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MODE:       cur_mode  = cfg_data_i[2:0];
          CFG_LINE_PAIRS: cur_pairs = cfg_data_i[11:0];
          CFG_FRAME_ROWS: cur_rows  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_pairs.push_back(upsample_pair(luma_first_i, luma_second_i, cb_upper_i,
                                               cb_lower_i, cr_upper_i, cr_lower_i));
      end
      n_waiting = expected_pairs.size();
    end
  end

endmodule

### tb/sv/yv12_to_yuy2_chroma_upsampler_tb.sv
// ----------------------------------------------------------------------------
// yv12_to_yuy2_chroma_upsampler_tb
// Drives pixel pairs and register settings into the chroma upsampler under
// random sender and receiver idling, including repeated long receiver hold-offs,
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yv12_to_yuy2_chroma_upsampler_tb;
  import yv2yuy_pkg::*;

  localparam logic [1:0] CFG_SPARE    = 2'd3;
  localparam int         TARGET_PAIRS = 720;
  localparam int         HOLD_CYCLES  = 150;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [12:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  luma_first_i;
  logic [7:0]  luma_second_i;
  logic [7:0]  cb_upper_i;
  logic [7:0]  cb_lower_i;
  logic [7:0]  cr_upper_i;
  logic [7:0]  cr_lower_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_y0_o;
  logic [7:0]  out_u_o;
  logic [7:0]  out_y1_o;
  logic [7:0]  out_v_o;
  logic        row_end_o;

  int mismatches;
  int outstanding;
  int tx_idle_pct;
  int rx_idle_pct;
  int pairs_sent;
  bit hold_req;

  yv12_to_yuy2_chroma_upsampler u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .luma_first_i  (luma_first_i),
    .luma_second_i (luma_second_i),
    .cb_upper_i    (cb_upper_i),
    .cb_lower_i    (cb_lower_i),
    .cr_upper_i    (cr_upper_i),
    .cr_lower_i    (cr_lower_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_y0_o      (out_y0_o),
    .out_u_o       (out_u_o),
    .out_y1_o      (out_y1_o),
    .out_v_o       (out_v_o),
    .row_end_o     (row_end_o)
  );

  chroma_pair_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .luma_first_i  (luma_first_i),
    .luma_second_i (luma_second_i),
    .cb_upper_i    (cb_upper_i),
    .cb_lower_i    (cb_lower_i),
    .cr_upper_i    (cr_upper_i),
    .cr_lower_i    (cr_lower_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_y0_i      (out_y0_o),
    .out_u_i       (out_u_o),
    .out_y1_i      (out_y1_o),
    .out_v_i       (out_v_o),
    .row_end_i     (row_end_o),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: random ready, with a long hold-off on request
  initial begin
    int hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_pair(input logic [7:0] y0, input logic [7:0] y1,
                           input logic [7:0] cbu, input logic [7:0] cbl,
                           input logic [7:0] cru, input logic [7:0] crl);
    if ($urandom_range(99) < tx_idle_pct) begin
      repeat ($urandom_range(1, 3)) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    luma_first_i  <= y0;
    luma_second_i <= y1;
    cb_upper_i    <= cbu;
    cb_lower_i    <= cbl;
    cr_upper_i    <= cru;
    cr_lower_i    <= crl;
    do @(posedge clk_i); while (!in_ready_o);
    pairs_sent++;
  endtask

  task automatic send_pattern(input int count);
    for (int k = 0; k < count; k++) begin
      send_pair(k[0] ? 8'hff : 8'h00, k[0] ? 8'h00 : 8'hff,
                k[1] ? 8'h00 : 8'hff, k[1] ? 8'hff : 8'h00,
                k[0] ? 8'hff : 8'h01, k[0] ? 8'h00 : 8'hfe);
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (outstanding == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic [2:0] mode, input logic [12:0] pairs,
                             input logic [12:0] rows);
    write_reg(CFG_MODE, {10'($urandom_range(1023)), mode});
    write_reg(CFG_LINE_PAIRS, pairs);
    write_reg(CFG_FRAME_ROWS, rows);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int          sel;
    int          n_items;
    int          phase_no;
    logic [12:0] pairs;
    logic [12:0] rows;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_MODE;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    luma_first_i  = '0;
    luma_second_i = '0;
    cb_upper_i    = '0;
    cb_lower_i    = '0;
    cr_upper_i    = '0;
    cr_lower_i    = '0;
    tx_idle_pct   = 24;
    rx_idle_pct   = 60;
    pairs_sent    = 0;
    hold_req      = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings, boundary and interior rows of one frame and one field set, then zero and oversized settings
    send_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pair(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    settle();
    reconfigure(MODE_FRAME1, 13'd1, 13'd4);
    send_pattern(4);
    settle();
    write_reg(CFG_SPARE, 13'h1fff);
    reconfigure(MODE_FIELD3, 13'd1, 13'd8);
    send_pattern(8);
    settle();
    reconfigure(MODE_FRAME_BOTTOM, 13'd0, 13'd0);
    send_pattern(3);
    settle();
    reconfigure(MODE_FIELD1, 13'd4095, 13'd8191);
    send_pattern(3);
    settle();

    phase_no = 0;
    while (pairs_sent < TARGET_PAIRS) begin
      if (pairs_sent < TARGET_PAIRS / 3) begin
        tx_idle_pct = 24;
        rx_idle_pct = 60;
      end else if (pairs_sent < 2 * TARGET_PAIRS / 3) begin
        tx_idle_pct = 60;
        rx_idle_pct = 24;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      sel   = $urandom_range(99);
      pairs = 13'($urandom_range(1, 6));
      rows  = 13'($urandom_range(0, 14));
      n_items = $urandom_range(20, 70);
      if (sel >= 90) begin
        case ($urandom_range(4))
          0:       pairs = 13'd0;
          1:       pairs = 13'd2047;
          2:       pairs = 13'd2048;
          3:       pairs = 13'd4095;
          default: pairs = 13'd8191;
        endcase
        n_items = $urandom_range(10, 40);
      end else if (sel >= 80) begin
        case ($urandom_range(3))
          0:       rows = 13'd4096;
          1:       rows = 13'd4097;
          2:       rows = 13'd8191;
          default: rows = 13'd1;
        endcase
      end
      reconfigure(3'($urandom_range(7)), pairs, rows);
      if (phase_no % 6 == 0) hold_req = 1'b1;
      repeat (n_items) begin
        send_pair(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom));
      end
      settle();
      phase_no++;
    end

    wait (outstanding == 0);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
